@@ rtl/rck_pkg.sv @@
// Package for the RF cavity longitudinal kick: item types, register indexes,
// fixed-point constants, pipeline stage map and helper functions.
// No dependencies.
package rck_pkg;

    localparam int SINE_ITERATIONS = 24;
    localparam int CORDIC_STAGES   = (SINE_ITERATIONS > 32) ? 32 : SINE_ITERATIONS;

    localparam int TW        = 47;
    localparam int RED_STEPS = 17;
    localparam int CW        = 34;

    localparam logic [TW-1:0]     TWO_PI    = 47'd1686629713;
    localparam logic signed [32:0] PI_Q28   = 33'sd843314857;
    localparam logic signed [32:0] HALF_PI  = 33'sd421657428;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [30:0]       ONE_Q30   = 31'd1073741824;

    localparam int ST_RED0 = 2;
    localparam int ST_FOLD = ST_RED0 + RED_STEPS;
    localparam int ST_COR0 = ST_FOLD + 1;
    localparam int ST_DIFF = ST_COR0 + CORDIC_STAGES;
    localparam int ST_PROD = ST_DIFF + 1;
    localparam int ST_OUT  = ST_PROD + 1;
    localparam int NSTG    = ST_OUT + 1;

    typedef enum logic [2:0] {
        REG_PHASE_PER_LENGTH = 3'd0,
        REG_SYNC_PHASE       = 3'd1,
        REG_KICK_AMPLITUDE   = 3'd2,
        REG_CORRECTION_MODE  = 3'd3,
        REG_VELOCITY_RATIO   = 3'd4,
        REG_ANGLE_DAMPING    = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_POSITION = 2'd1,
        MODE_ENERGY   = 2'd2
    } corr_mode_t;

    typedef struct packed {
        logic signed [31:0] z_in;
        logic signed [31:0] de_in;
        logic signed [31:0] xp_in;
        logic signed [31:0] yp_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] z_out;
        logic signed [31:0] de_out;
        logic signed [31:0] xp_out;
        logic signed [31:0] yp_out;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] xp;
        logic signed [31:0] yp;
        logic               flag;
        logic signed [57:0] de48;
        logic [30:0]        s0ang;
    } side_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [67:0] v);
        sat_t s;
        s.ovf = 1'b0;
        s.val = 32'(v);
        if (v > 68'sd2147483647) begin
            s.ovf = 1'b1;
            s.val = 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            s.ovf = 1'b1;
            s.val = 32'sh80000000;
        end
        return s;
    endfunction

    // Shift-and-subtract quotient, used only on constants at elaboration.
    function automatic longint unsigned long_quot(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q4.28 from its power series in Q60, rounded.
    function automatic logic signed [31:0] atan_q28(input int i);
        longint sum;
        longint unsigned term;
        int n;
        int p;
        sum = 0;
        if (i == 0) begin
            return 32'sd210828714;
        end
        for (int k = 0; k < 31; k++) begin
            n = 2 * k + 1;
            p = 60 - i * n;
            if (p >= 0) begin
                term = long_quot(64'd1 << p, 64'(n));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        return 32'((longint'(unsigned'(sum)) + 64'sd2147483648) >>> 32);
    endfunction

    // Wrap an angle in [0, 2pi) to [-pi, pi) and fold it into [-pi/2, pi/2].
    function automatic logic signed [31:0] fold_angle(input logic [30:0] r);
        logic signed [32:0] v;
        v = $signed({2'b00, r});
        if (v >= PI_Q28) begin
            v = v - $signed({2'b00, TWO_PI[30:0]});
        end
        if (v > HALF_PI) begin
            v = PI_Q28 - v;
        end else if (v < -HALF_PI) begin
            v = -PI_Q28 - v;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/rck_cordic.sv @@
// Two-lane pipelined rotation CORDIC, one iteration per register stage.
// Depends on rck_pkg for the iteration count, gain and atan table.
module rck_cordic import rck_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [31:0]   ang_a,
    input  logic signed [31:0]   ang_b,
    output logic signed [CW-1:0] sin_a,
    output logic signed [CW-1:0] sin_b
);

    logic signed [CW-1:0] x_reg [2][CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [2][CORDIC_STAGES];
    logic signed [31:0]   r_reg [2][CORDIC_STAGES];
    logic signed [31:0]   ang   [2];

    assign ang[0] = ang_a;
    assign ang[1] = ang_b;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
            localparam logic signed [31:0] AT = atan_q28(i);
            logic signed [CW-1:0] xi;
            logic signed [CW-1:0] yi;
            logic signed [31:0]   ri;
            if (i == 0) begin : g_first
                assign xi = GAIN_Q30;
                assign yi = '0;
                assign ri = ang[l];
            end else begin : g_next
                assign xi = x_reg[l][i-1];
                assign yi = y_reg[l][i-1];
                assign ri = r_reg[l][i-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (ri >= 0) begin
                        x_reg[l][i] <= xi - (yi >>> i);
                        y_reg[l][i] <= yi + (xi >>> i);
                        r_reg[l][i] <= ri - AT;
                    end else begin
                        x_reg[l][i] <= xi + (yi >>> i);
                        y_reg[l][i] <= yi - (xi >>> i);
                        r_reg[l][i] <= ri + AT;
                    end
                end
            end
        end
    end

    assign sin_a = y_reg[0][CORDIC_STAGES-1];
    assign sin_b = y_reg[1][CORDIC_STAGES-1];

endmodule

@@ rtl/rf_cavity_longitudinal_kick.sv @@
// Top level of the RF cavity thin longitudinal kick pipeline.
// Depends on rck_pkg and rck_cordic.
//
// One particle enters per item on the s_ channel (s_valid, s_ready, s_data)
// and one result item leaves on the m_ channel (m_valid, m_ready, m_data).
// The cfg_ channel writes the six registers by index; unknown indexes are
// ignored, and registers are meant to be written while the pipeline is empty.
// Throughput is one item per cycle while the output is not stalled. The depth
// is set by the sine CORDIC, one iteration per stage, and by the modulo-2pi
// reduction, one compare and subtract per stage over 17 stages.
// The whole pipeline advances together: when a result waits on m_ with
// m_ready low, every stage holds and s_ready drops, so nothing is lost or
// repeated, and a new item is accepted in the same cycle that the last is
// taken. Reset clears the stage valid bits and loads the register defaults
// (ratios 1.0, all others zero); items in flight are dropped.
module rf_cavity_longitudinal_kick import rck_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic signed [31:0] ppl_reg;
    logic signed [30:0] sph_reg;
    logic signed [31:0] amp_reg;
    logic [1:0]         mode_reg;
    logic [30:0]        vr_reg;
    logic [30:0]        ad_reg;

    logic [NSTG-1:0]    vld_reg;
    logic               en;

    logic signed [63:0] kz_reg;
    logic signed [63:0] dek_reg;
    logic signed [63:0] zv_reg;
    logic signed [63:0] xa_reg;
    logic signed [63:0] ya_reg;
    logic signed [31:0] z0_reg;

    logic [TW-1:0]      theta_reg;
    logic [TW-1:0]      red_reg [RED_STEPS];
    side_t              side_reg [1:ST_PROD];
    side_t              side_next;

    logic signed [31:0] ang1_reg;
    logic signed [31:0] ang0_reg;
    logic signed [CW-1:0] sin1;
    logic signed [CW-1:0] sin0;
    logic signed [34:0] diff_reg;
    logic signed [66:0] prod_reg;
    out_item_t          out_reg;
    out_item_t          out_next;

    logic [30:0]        ek;
    logic signed [64:0] negkz;
    logic signed [47:0] theta_next;
    logic signed [32:0] s0_sum;
    sat_t               sz;
    sat_t               sx;
    sat_t               sy;
    sat_t               sd;
    logic signed [67:0] de_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppl_reg  <= '0;
            sph_reg  <= '0;
            amp_reg  <= '0;
            mode_reg <= MODE_NONE;
            vr_reg   <= ONE_Q30;
            ad_reg   <= ONE_Q30;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PHASE_PER_LENGTH: ppl_reg  <= $signed(cfg_data);
                REG_SYNC_PHASE:       sph_reg  <= $signed(cfg_data[30:0]);
                REG_KICK_AMPLITUDE:   amp_reg  <= $signed(cfg_data);
                REG_CORRECTION_MODE:  mode_reg <= cfg_data[1:0];
                REG_VELOCITY_RATIO:   vr_reg   <= cfg_data[30:0];
                REG_ANGLE_DAMPING:    ad_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign en      = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NSTG-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    assign ek = (mode_reg == MODE_ENERGY) ? vr_reg : ONE_Q30;

    always_ff @(posedge aclk) begin
        if (en) begin
            kz_reg  <= ppl_reg * s_data.z_in;
            dek_reg <= s_data.de_in * $signed({1'b0, ek});
            zv_reg  <= s_data.z_in * $signed({1'b0, vr_reg});
            xa_reg  <= s_data.xp_in * $signed({1'b0, ad_reg});
            ya_reg  <= s_data.yp_in * $signed({1'b0, ad_reg});
            z0_reg  <= s_data.z_in;
        end
    end

    // The phase is reduced as floor(-k*z / 2^20) + sync phase, offset to
    // stay positive by a multiple of two pi.
    always_comb begin
        negkz      = -65'(kz_reg);
        theta_next = 48'(negkz >>> 20) + 48'(sph_reg)
                     + $signed({1'b0, TWO_PI << 15});
        s0_sum     = 33'(sph_reg) + $signed({2'b00, TWO_PI[30:0]});
        if (s0_sum >= $signed({2'b00, TWO_PI[30:0]})) begin
            s0_sum = s0_sum - $signed({2'b00, TWO_PI[30:0]});
        end
        sz = sat32(68'(zv_reg >>> 30));
        sx = sat32(68'(xa_reg >>> 30));
        sy = sat32(68'(ya_reg >>> 30));
        side_next.z     = (mode_reg == MODE_POSITION) ? sz.val : z0_reg;
        side_next.xp    = sx.val;
        side_next.yp    = sy.val;
        side_next.flag  = ((mode_reg == MODE_POSITION) && sz.ovf) || sx.ovf || sy.ovf;
        side_next.de48  = 58'(dek_reg >>> 6);
        side_next.s0ang = s0_sum[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            theta_reg   <= theta_next[TW-1:0];
            side_reg[1] <= side_next;
        end
    end

    for (genvar s = 2; s <= ST_PROD; s++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
        localparam logic [TW-1:0] STEP = TWO_PI << (RED_STEPS - 1 - k);
        logic [TW-1:0] rin;
        if (k == 0) begin : g_first
            assign rin = theta_reg;
        end else begin : g_next
            assign rin = red_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                red_reg[k] <= (rin >= STEP) ? rin - STEP : rin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang1_reg <= fold_angle(red_reg[RED_STEPS-1][30:0]);
            ang0_reg <= fold_angle(side_reg[ST_FOLD-1].s0ang);
        end
    end

    rck_cordic u_cordic (
        .aclk  (aclk),
        .en    (en),
        .ang_a (ang1_reg),
        .ang_b (ang0_reg),
        .sin_a (sin1),
        .sin_b (sin0)
    );

    always_comb begin
        de_sum = 68'(side_reg[ST_PROD].de48) + 68'(prod_reg >>> 6);
        sd     = sat32(68'(de_sum >>> 24));
        out_next.z_out     = side_reg[ST_PROD].z;
        out_next.de_out    = sd.val;
        out_next.xp_out    = side_reg[ST_PROD].xp;
        out_next.yp_out    = side_reg[ST_PROD].yp;
        out_next.saturated = side_reg[ST_PROD].flag || sd.ovf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg <= 35'(sin1) - 35'(sin0);
            prod_reg <= 67'(amp_reg) * 67'(diff_reg);
            out_reg  <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while a result is stalled");

    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_FOLD-1] |-> (red_reg[RED_STEPS-1] < TWO_PI))
        else $error("phase reduction left a value of two pi or more");

    a_folded: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ST_FOLD] |-> ((33'(ang1_reg) <= HALF_PI) && (33'(ang1_reg) >= -HALF_PI)))
        else $error("folded angle outside minus to plus half pi");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid) |-> s_ready)
        else $error("pipeline stalled with no result waiting");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the RF cavity longitudinal kick pipeline.
// Depends on rck_pkg and rf_cavity_longitudinal_kick; predicts each result in
// the bench and compares it field by field under random idling and a long stall.
module testbench;
    import rck_pkg::*;

    localparam longint TWO_PI_C  = 64'sd1686629713;
    localparam longint PI_C      = 64'sd843314857;
    localparam longint HALF_PI_C = 64'sd421657428;
    localparam longint GAIN_C    = 64'sd652032874;
    localparam longint UNITY_C   = 64'sd1073741824;
    localparam int     LATENCY   = 23 + SINE_ITERATIONS;
    localparam int     STALL_MAX = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    longint    k_phase;
    longint    phi_sync;
    longint    amp;
    logic[1:0] mode_reg;
    longint    beta_ratio;
    longint    damp_ratio;
    longint    atan_tab[32];

    out_item_t kick_queue[$];
    int        errors;
    int        idle_cycles;
    int        send_idle;
    int        recv_idle;
    bit        hold_off;

    rf_cavity_longitudinal_kick u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void fill_atan();
        longint sum;
        longint term;
        int p;
        atan_tab[0] = 210828714;
        for (int i = 1; i < 32; i++) begin
            sum = 0;
            for (int k = 0; k < 40; k++) begin
                p = 60 - i * (2 * k + 1);
                if (p >= 0) begin
                    term = longint'((64'd1 << p) / (2 * k + 1));
                    sum = (k % 2 == 1) ? sum - term : sum + term;
                end
            end
            atan_tab[i] = longint'((64'(sum) + 64'd2147483648) >> 32);
        end
    endfunction

    function automatic longint sine_q30(longint theta);
        longint r;
        longint x;
        longint y;
        longint nx;
        r = theta % TWO_PI_C;
        x = GAIN_C;
        y = 0;
        if (r < 0) r += TWO_PI_C;
        if (r >= PI_C) r -= TWO_PI_C;
        if (r > HALF_PI_C) r = PI_C - r;
        else if (r < -HALF_PI_C) r = -PI_C - r;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (r >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                r -= atan_tab[i];
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                r += atan_tab[i];
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic out_item_t predict_kick(in_item_t p);
        out_item_t o;
        bit flag;
        longint z;
        longint ph;
        longint modulus;
        longint kick48;
        longint de48;
        longint ek;
        flag = 0;
        z = p.z_in;
        modulus = TWO_PI_C * (64'sd1 <<< 20);
        ph = -(k_phase * z);
        ph = ph % modulus;
        if (ph < 0) ph += modulus;
        ph = ph >>> 20;
        kick48 = floor_shift(amp * (sine_q30(phi_sync + ph) - sine_q30(phi_sync)), 6);
        ek = (mode_reg == MODE_ENERGY) ? beta_ratio : UNITY_C;
        de48 = floor_shift(longint'(p.de_in) * ek, 6);
        o.de_out = 32'(clip32(floor_shift(de48 + kick48, 24), flag));
        o.z_out = (mode_reg == MODE_POSITION) ?
                  32'(clip32(floor_shift(z * beta_ratio, 30), flag)) : p.z_in;
        o.xp_out = 32'(clip32(floor_shift(longint'(p.xp_in) * damp_ratio, 30), flag));
        o.yp_out = 32'(clip32(floor_shift(longint'(p.yp_in) * damp_ratio, 30), flag));
        o.saturated = flag;
        return o;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PHASE_PER_LENGTH: k_phase    = longint'(signed'(val));
            REG_SYNC_PHASE:       phi_sync   = longint'(signed'(val[30:0]));
            REG_KICK_AMPLITUDE:   amp        = longint'(signed'(val));
            REG_CORRECTION_MODE:  mode_reg   = val[1:0];
            REG_VELOCITY_RATIO:   beta_ratio = longint'(val[30:0]);
            REG_ANGLE_DAMPING:    damp_ratio = longint'(val[30:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_unknown(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (kick_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // Sends one item and queues its prediction; an optional typed-in result
    // overrides the predictor where it can be read off directly.
    task automatic send_particle(in_item_t p, bit typed, out_item_t want);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        kick_queue.push_back(typed ? want : predict_kick(p));
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (kick_queue.size() == 0) begin
                $display("%0t: unexpected item %h", $time, m_data);
                errors++;
            end else begin
                if (m_data.z_out !== kick_queue[0].z_out) begin
                    $display("%0t: z_out expected %h actual %h", $time,
                             kick_queue[0].z_out, m_data.z_out);
                    errors++;
                end
                if (m_data.de_out !== kick_queue[0].de_out) begin
                    $display("%0t: de_out expected %h actual %h", $time,
                             kick_queue[0].de_out, m_data.de_out);
                    errors++;
                end
                if (m_data.xp_out !== kick_queue[0].xp_out) begin
                    $display("%0t: xp_out expected %h actual %h", $time,
                             kick_queue[0].xp_out, m_data.xp_out);
                    errors++;
                end
                if (m_data.yp_out !== kick_queue[0].yp_out) begin
                    $display("%0t: yp_out expected %h actual %h", $time,
                             kick_queue[0].yp_out, m_data.yp_out);
                    errors++;
                end
                if (m_data.saturated !== kick_queue[0].saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             kick_queue[0].saturated, m_data.saturated);
                    errors++;
                end
                void'(kick_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn || hold_off) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_MAX) begin
                $display("FAIL rf_cavity_longitudinal_kick");
                $finish;
            end
        end
    end

    typedef struct {
        logic [31:0] z;
        logic [31:0] de;
        logic [31:0] xp;
        logic [31:0] yp;
        bit          typed;
        logic [31:0] zo;
        logic [31:0] deo;
        logic [31:0] xo;
        logic [31:0] yo;
        bit          sat;
    } stim_row_t;

    stim_row_t reset_rows[] = '{
        '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1,
          32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 0},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0},
        '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
          32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0},
        '{32'h01000000, 32'hFF000000, 32'h00000001, 32'hFFFFFFFF, 1,
          32'h01000000, 32'hFF000000, 32'h00000001, 32'hFFFFFFFF, 0}
    };

    stim_row_t kick_rows[] = '{
        '{32'h00000000, 32'h01000000, 32'h00800000, 32'hFF800000, 0, 0, 0, 0, 0, 0},
        '{32'h00400000, 32'h00000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0, 0},
        '{32'hFFC00000, 32'h7FFFFFFF, 32'h00000000, 32'h00000000, 0, 0, 0, 0, 0, 0},
        '{32'h7FFFFFFF, 32'h80000000, 32'h12345678, 32'hEDCBA988, 0, 0, 0, 0, 0, 0},
        '{32'h80000000, 32'h40000000, 32'h00000001, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0},
        '{32'h03243F6A, 32'hC0000000, 32'h55555555, 32'hAAAAAAAA, 0, 0, 0, 0, 0, 0}
    };

    task automatic walk_rows(stim_row_t rows[]);
        in_item_t  p;
        out_item_t w;
        foreach (rows[i]) begin
            p = '{rows[i].z, rows[i].de, rows[i].xp, rows[i].yp};
            w = '{rows[i].zo, rows[i].deo, rows[i].xo, rows[i].yo, rows[i].sat};
            send_particle(p, rows[i].typed, w);
        end
        s_valid <= 1'b0;
    endtask

    task automatic random_config();
        write_reg(REG_PHASE_PER_LENGTH, ($urandom_range(3) == 0) ? $urandom :
                  32'(signed'($urandom_range(1 << 26)) - (1 << 25)));
        write_reg(REG_SYNC_PHASE, {1'b0, 31'($urandom)});
        write_reg(REG_KICK_AMPLITUDE, rand_field());
        write_reg(REG_CORRECTION_MODE, 32'($urandom_range(3)));
        write_reg(REG_VELOCITY_RATIO, ($urandom_range(1) == 1) ? $urandom :
                  32'($urandom_range(32'h48000000, 32'h38000000)));
        write_reg(REG_ANGLE_DAMPING, ($urandom_range(1) == 1) ? $urandom :
                  32'($urandom_range(32'h42000000, 32'h3E000000)));
    endtask

    task automatic random_items(int count);
        in_item_t p;
        out_item_t none;
        none = '0;
        for (int i = 0; i < count; i++) begin
            p = '{rand_field(), rand_field(), rand_field(), rand_field()};
            send_particle(p, 0, none);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        errors      = 0;
        send_idle   = 0;
        recv_idle   = 0;
        hold_off    = 0;
        idle_cycles = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_PHASE_PER_LENGTH;
        cfg_data    = '0;
        k_phase     = 0;
        phi_sync    = 0;
        amp         = 0;
        mode_reg    = MODE_NONE;
        beta_ratio  = UNITY_C;
        damp_ratio  = UNITY_C;
        fill_atan();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        walk_rows(reset_rows);
        drain();

        write_reg(REG_PHASE_PER_LENGTH, 32'h06487ED5);
        write_reg(REG_SYNC_PHASE, 32'h7FFFFFFF);
        write_reg(REG_KICK_AMPLITUDE, 32'h7FFFFFFF);
        write_reg(REG_CORRECTION_MODE, MODE_POSITION);
        write_reg(REG_VELOCITY_RATIO, 32'h7FFFFFFF);
        write_reg(REG_ANGLE_DAMPING, 32'h7FFFFFFF);
        write_unknown(3'd6, 32'hFFFFFFFF);
        write_unknown(3'd7, 32'h00000000);
        walk_rows(kick_rows);
        drain();

        write_reg(REG_PHASE_PER_LENGTH, 32'h80000000);
        write_reg(REG_SYNC_PHASE, 32'h40000000);
        write_reg(REG_KICK_AMPLITUDE, 32'h80000000);
        write_reg(REG_CORRECTION_MODE, MODE_ENERGY);
        write_reg(REG_VELOCITY_RATIO, 32'h00000000);
        write_reg(REG_ANGLE_DAMPING, 32'h00000000);
        walk_rows(kick_rows);
        drain();

        write_reg(REG_CORRECTION_MODE, 32'd3);
        write_reg(REG_SYNC_PHASE, 32'h3243F6A9);
        write_reg(REG_VELOCITY_RATIO, 32'h40000000);
        write_reg(REG_ANGLE_DAMPING, 32'h40000000);
        walk_rows(kick_rows);
        drain();

        send_idle = 6;
        recv_idle = 84;
        for (int ph = 0; ph < 3; ph++) begin
            random_config();
            random_items(50);
            drain();
        end

        send_idle = 84;
        recv_idle = 6;
        for (int ph = 0; ph < 3; ph++) begin
            random_config();
            random_items(50);
            drain();
        end

        send_idle = 0;
        recv_idle = 0;
        random_config();
        fork
            random_items(150);
            begin
                repeat (10) @(posedge aclk);
                hold_off = 1;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 0;
            end
        join
        drain();

        if (errors == 0) begin
            $display("PASS rf_cavity_longitudinal_kick");
        end else begin
            $display("FAIL rf_cavity_longitudinal_kick");
        end
        $finish;
    end
endmodule
